>>> rtl/ccs_pkg.sv
`default_nettype none

package ccs_pkg;

  // Deepest run of trailing whitespace that can be held back before it must be released.
  localparam int unsigned MaxPendingSpace = 32;

  // Depth of the token queue between the front and the back.
  localparam int unsigned QueueDepth = 4;

  localparam logic [7:0] CharNewline   = 8'h0A;
  localparam logic [7:0] CharSlash     = 8'h2F;
  localparam logic [7:0] CharStar      = 8'h2A;
  localparam logic [7:0] CharBackslash = 8'h5C;
  localparam logic [7:0] CharSpace     = 8'h20;
  localparam logic [7:0] CharTab       = 8'h09;
  localparam logic [7:0] CharCr        = 8'h0D;
  localparam logic [7:0] CharVt        = 8'h0B;
  localparam logic [7:0] CharFf        = 8'h0C;

  typedef enum logic [1:0] {
    ModeNormal = 2'd0,
    ModeLine   = 2'd1,
    ModeBlock  = 2'd2
  } scan_mode_e;

  typedef enum logic [2:0] {
    FrontIdle,
    FrontBslash,
    FrontSpace,
    FrontChar,
    FrontEnd
  } front_state_e;

  typedef enum logic {
    TokChar,
    TokEnd
  } tok_kind_e;

  // One unit of work for the comment scanner: a character, or the end of an input beat.
  typedef struct packed {
    tok_kind_e  kind;
    logic [7:0] data;
    logic       lost;
    logic       eot;
  } tok_t;

  function automatic logic is_blank(logic [7:0] c);
    return (c == CharSpace) || (c == CharTab) || (c == CharCr) ||
           (c == CharVt) || (c == CharFf);
  endfunction

endpackage

`default_nettype wire

>>> rtl/ccs_front.sv
`default_nettype none

module ccs_front #(
  parameter int unsigned MaxPending = ccs_pkg::MaxPendingSpace
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_ready_o,
  input  wire logic          kind_i,
  input  wire logic [7:0]    in_byte_i,
  output logic               tok_valid_o,
  input  wire logic          tok_ready_i,
  output ccs_pkg::tok_t      tok_o
);

  localparam int unsigned AW = (MaxPending > 1) ? $clog2(MaxPending) : 1;
  localparam int unsigned CW = $clog2(MaxPending + 1);
  localparam logic [CW-1:0] CountMax = CW'(MaxPending);

  ccs_pkg::front_state_e state_q, state_d;

  logic          bs_held_q, bs_held_d;
  logic [CW-1:0] count_q, count_d;
  logic          line_open_q, line_open_d;
  logic [7:0]    char_q, char_d;
  logic          lost_q, lost_d;
  logic          eot_q, eot_d;
  logic          need_sp_q, need_sp_d;
  logic          need_c_q, need_c_d;
  logic [CW-1:0] flush_len_q, flush_len_d;
  logic [AW-1:0] idx_q, idx_d;

  logic [7:0]    space_mem [MaxPending];
  logic [7:0]    rd_data_q;
  logic          mem_we;

  logic accept, tok_fire, last_sp;
  logic is_nl, is_bl, is_bs, is_other, overflow, flush;
  logic need_bs, need_sp, need_c, need_end;

  assign accept   = in_valid_i && in_ready_o;
  assign tok_fire = tok_valid_o && tok_ready_i;
  assign last_sp  = (CW'(idx_q) + CW'(1)) == flush_len_q;

  // Classify the incoming beat.
  assign is_nl    = !kind_i && (in_byte_i == ccs_pkg::CharNewline);
  assign is_bl    = !kind_i && ccs_pkg::is_blank(in_byte_i);
  assign is_bs    = !kind_i && (in_byte_i == ccs_pkg::CharBackslash);
  assign is_other = !kind_i && !is_nl && !is_bl && !is_bs;
  assign overflow = is_bl && (count_q == CountMax);
  assign flush    = overflow || is_bs || is_other;
  assign need_bs  = flush && bs_held_q;
  assign need_sp  = flush && (count_q != '0);
  assign need_c   = is_other || overflow || (is_nl && !bs_held_q) || (kind_i && line_open_q);
  assign need_end = need_bs || need_sp || need_c || kind_i;

  always_comb begin
    state_d = state_q;
    case (state_q)
      ccs_pkg::FrontIdle: begin
        if (accept) begin
          if (need_bs) begin
            state_d = ccs_pkg::FrontBslash;
          end else if (need_sp) begin
            state_d = ccs_pkg::FrontSpace;
          end else if (need_c) begin
            state_d = ccs_pkg::FrontChar;
          end else if (need_end) begin
            state_d = ccs_pkg::FrontEnd;
          end
        end
      end
      ccs_pkg::FrontBslash: begin
        if (tok_fire) begin
          if (need_sp_q) begin
            state_d = ccs_pkg::FrontSpace;
          end else if (need_c_q) begin
            state_d = ccs_pkg::FrontChar;
          end else begin
            state_d = ccs_pkg::FrontEnd;
          end
        end
      end
      ccs_pkg::FrontSpace: begin
        if (tok_fire && last_sp) begin
          state_d = need_c_q ? ccs_pkg::FrontChar : ccs_pkg::FrontEnd;
        end
      end
      ccs_pkg::FrontChar: begin
        if (tok_fire) begin
          state_d = ccs_pkg::FrontEnd;
        end
      end
      ccs_pkg::FrontEnd: begin
        if (tok_fire) begin
          state_d = ccs_pkg::FrontIdle;
        end
      end
      default: state_d = ccs_pkg::FrontIdle;
    endcase
  end

  always_comb begin
    in_ready_o  = 1'b0;
    tok_valid_o = 1'b1;
    tok_o.kind  = ccs_pkg::TokChar;
    tok_o.data  = char_q;
    tok_o.lost  = lost_q;
    tok_o.eot   = eot_q;
    case (state_q)
      ccs_pkg::FrontIdle: begin
        in_ready_o  = 1'b1;
        tok_valid_o = 1'b0;
      end
      ccs_pkg::FrontBslash: tok_o.data = ccs_pkg::CharBackslash;
      ccs_pkg::FrontSpace:  tok_o.data = rd_data_q;
      ccs_pkg::FrontChar:   tok_o.data = char_q;
      ccs_pkg::FrontEnd:    tok_o.kind = ccs_pkg::TokEnd;
      default:              tok_valid_o = 1'b0;
    endcase
  end

  // Line state, whitespace buffer bookkeeping and the captured beat.
  always_comb begin
    bs_held_d   = bs_held_q;
    count_d     = count_q;
    line_open_d = line_open_q;
    char_d      = char_q;
    lost_d      = lost_q;
    eot_d       = eot_q;
    need_sp_d   = need_sp_q;
    need_c_d    = need_c_q;
    flush_len_d = flush_len_q;
    mem_we      = 1'b0;
    idx_d       = idx_q;
    if (accept) begin
      char_d      = kind_i ? ccs_pkg::CharNewline : in_byte_i;
      lost_d      = overflow;
      eot_d       = kind_i;
      need_sp_d   = need_sp;
      need_c_d    = need_c;
      flush_len_d = count_q;
      if (kind_i) begin
        count_d     = '0;
        bs_held_d   = 1'b0;
        line_open_d = 1'b0;
      end else if (is_nl) begin
        count_d     = '0;
        bs_held_d   = 1'b0;
        line_open_d = bs_held_q;
      end else begin
        line_open_d = 1'b1;
        if (is_bl && !overflow) begin
          mem_we  = 1'b1;
          count_d = count_q + CW'(1);
        end else begin
          count_d   = '0;
          bs_held_d = is_bs;
        end
      end
    end
    if ((state_q == ccs_pkg::FrontSpace) && tok_fire) begin
      idx_d = last_sp ? '0 : idx_q + AW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      space_mem[count_q[AW-1:0]] <= in_byte_i;
    end
    rd_data_q <= space_mem[idx_d];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ccs_pkg::FrontIdle;
      bs_held_q   <= 1'b0;
      count_q     <= '0;
      line_open_q <= 1'b0;
      need_sp_q   <= 1'b0;
      need_c_q    <= 1'b0;
      flush_len_q <= '0;
      idx_q       <= '0;
    end else begin
      state_q     <= state_d;
      bs_held_q   <= bs_held_d;
      count_q     <= count_d;
      line_open_q <= line_open_d;
      need_sp_q   <= need_sp_d;
      need_c_q    <= need_c_d;
      flush_len_q <= flush_len_d;
      idx_q       <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    char_q <= char_d;
    lost_q <= lost_d;
    eot_q  <= eot_d;
  end

endmodule

`default_nettype wire

>>> rtl/ccs_queue.sv
`default_nettype none

module ccs_queue (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           push_valid_i,
  output logic                push_ready_o,
  input  wire ccs_pkg::tok_t  push_tok_i,
  output logic                pop_valid_o,
  input  wire logic           pop_ready_i,
  output ccs_pkg::tok_t       pop_tok_o
);

  localparam int unsigned Depth = ccs_pkg::QueueDepth;
  localparam int unsigned PW    = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CW    = $clog2(Depth + 1);
  localparam logic [PW-1:0] LastSlot = PW'(Depth - 1);

  ccs_pkg::tok_t slots_q [Depth];
  logic [PW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CW-1:0] count_q;
  logic          do_push, do_pop;

  assign push_ready_o = count_q != CW'(Depth);
  assign pop_valid_o  = count_q != '0;
  assign pop_tok_o    = slots_q[rd_ptr_q];
  assign do_push      = push_valid_i && push_ready_o;
  assign do_pop       = pop_valid_o && pop_ready_i;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slots_q[wr_ptr_q] <= push_tok_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == LastSlot) ? '0 : wr_ptr_q + PW'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == LastSlot) ? '0 : rd_ptr_q + PW'(1);
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + CW'(1);
      end else if (do_pop && !do_push) begin
        count_q <= count_q - CW'(1);
      end
    end
  end

endmodule

`default_nettype wire

>>> rtl/ccs_back.sv
`default_nettype none

module ccs_back (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           tok_valid_i,
  output logic                tok_ready_o,
  input  wire ccs_pkg::tok_t  tok_i,
  output logic                out_valid_o,
  input  wire logic           out_ready_i,
  output logic                byte_valid_o,
  output logic [7:0]          out_byte_o,
  output logic                last_of_run_o,
  output logic                trim_lost_o,
  output logic                text_done_o
);

  ccs_pkg::scan_mode_e mode_q, mode_d;
  logic       slash_q, slash_d;
  logic       star_q, star_d;
  logic       hold_valid_q, hold_valid_d;
  logic [7:0] hold_byte_q, hold_byte_d;
  logic       hold_lost_q, hold_lost_d;

  logic       out_valid_q, out_valid_d;
  logic       obv_q, obv_d;
  logic [7:0] obyte_q, obyte_d;
  logic       olast_q, olast_d;
  logic       olost_q, olost_d;
  logic       odone_q, odone_d;

  logic       emit, split, need_out, out_free, go, is_end;
  logic [7:0] emit_byte;

  assign is_end   = tok_i.kind == ccs_pkg::TokEnd;
  assign out_free = !out_valid_q || out_ready_i;
  assign need_out = is_end ? (hold_valid_q || tok_i.eot) : (emit && hold_valid_q);
  assign go       = tok_valid_i && (!need_out || out_free);
  // A held slash before an ordinary character emits the slash first, then reuses the token.
  assign tok_ready_o = go && !split;

  // Comment scanner for one token: a character or the closing token of a beat.
  always_comb begin
    mode_d    = mode_q;
    slash_d   = slash_q;
    star_d    = star_q;
    emit      = 1'b0;
    split     = 1'b0;
    emit_byte = tok_i.data;
    if (is_end) begin
      if (tok_i.eot) begin
        mode_d  = ccs_pkg::ModeNormal;
        slash_d = 1'b0;
        star_d  = 1'b0;
      end
    end else begin
      case (mode_q)
        ccs_pkg::ModeLine: begin
          if (tok_i.data == ccs_pkg::CharNewline) begin
            emit   = 1'b1;
            mode_d = ccs_pkg::ModeNormal;
          end
        end
        ccs_pkg::ModeBlock: begin
          if (star_q && (tok_i.data == ccs_pkg::CharSlash)) begin
            mode_d = ccs_pkg::ModeNormal;
            star_d = 1'b0;
          end else begin
            star_d = tok_i.data == ccs_pkg::CharStar;
          end
        end
        default: begin
          mode_d = ccs_pkg::ModeNormal;
          if (slash_q) begin
            slash_d = 1'b0;
            if (tok_i.data == ccs_pkg::CharSlash) begin
              mode_d = ccs_pkg::ModeLine;
            end else if (tok_i.data == ccs_pkg::CharStar) begin
              mode_d = ccs_pkg::ModeBlock;
              star_d = 1'b0;
            end else begin
              emit      = 1'b1;
              split     = 1'b1;
              emit_byte = ccs_pkg::CharSlash;
            end
          end else if (tok_i.data == ccs_pkg::CharSlash) begin
            slash_d = 1'b1;
          end else begin
            emit = 1'b1;
          end
        end
      endcase
    end
  end

  // The newest emitted character waits in the hold stage until it is known whether it
  // is the last one of its input beat.
  always_comb begin
    hold_valid_d = hold_valid_q;
    hold_byte_d  = hold_byte_q;
    hold_lost_d  = hold_lost_q;
    out_valid_d  = out_valid_q && !out_ready_i;
    obv_d        = obv_q;
    obyte_d      = obyte_q;
    olast_d      = olast_q;
    olost_d      = olost_q;
    odone_d      = odone_q;
    if (go && need_out) begin
      out_valid_d = 1'b1;
      obv_d       = hold_valid_q;
      obyte_d     = hold_valid_q ? hold_byte_q : '0;
      olost_d     = hold_valid_q && hold_lost_q;
      olast_d     = is_end;
      odone_d     = is_end && tok_i.eot;
    end
    if (go) begin
      if (is_end) begin
        hold_valid_d = 1'b0;
      end else if (emit) begin
        hold_valid_d = 1'b1;
        hold_byte_d  = emit_byte;
        hold_lost_d  = tok_i.lost;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q       <= ccs_pkg::ModeNormal;
      slash_q      <= 1'b0;
      star_q       <= 1'b0;
      hold_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      if (go) begin
        mode_q  <= mode_d;
        slash_q <= slash_d;
        star_q  <= star_d;
      end
      hold_valid_q <= hold_valid_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    hold_byte_q <= hold_byte_d;
    hold_lost_q <= hold_lost_d;
    obv_q       <= obv_d;
    obyte_q     <= obyte_d;
    olast_q     <= olast_d;
    olost_q     <= olost_d;
    odone_q     <= odone_d;
  end

  assign out_valid_o   = out_valid_q;
  assign byte_valid_o  = obv_q;
  assign out_byte_o    = obyte_q;
  assign last_of_run_o = olast_q;
  assign trim_lost_o   = olost_q;
  assign text_done_o   = odone_q;

endmodule

`default_nettype wire

>>> rtl/c_comment_stripper.sv
// Channel   Direction  Handshake                  Beat contents
// input     in         in_valid_i / in_ready_o    kind_i, in_byte_i
// output    out        out_valid_o / out_ready_i  byte_valid_o, out_byte_o, last_of_run_o,
//                                                 trim_lost_o, text_done_o
//
// A beat that only buffers whitespace, holds a backslash or splices a line is taken
// without issuing tokens. Any other beat keeps the front busy while it issues its tokens:
// one per released whitespace byte or backslash, one for the character, and a closing
// token. Reset clears the line state, the scanner mode, the token queue and the output
// register; the whitespace buffer is not cleared.
// The front stalls on a full token queue, the back only on a full output register.
`default_nettype none

module c_comment_stripper #(
  parameter int unsigned MaxPending = ccs_pkg::MaxPendingSpace
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic        kind_i,
  input  wire logic [7:0]  in_byte_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic             byte_valid_o,
  output logic [7:0]       out_byte_o,
  output logic             last_of_run_o,
  output logic             trim_lost_o,
  output logic             text_done_o
);

  // The front trims whitespace, splices continued lines and turns each input beat into
  // a list of character tokens followed by a closing token, or into no token at all.
  ccs_pkg::tok_t front_tok, back_tok;
  logic          front_valid, front_ready;
  logic          back_valid, back_ready;

  ccs_front #(
    .MaxPending (MaxPending)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .kind_i      (kind_i),
    .in_byte_i   (in_byte_i),
    .tok_valid_o (front_valid),
    .tok_ready_i (front_ready),
    .tok_o       (front_tok)
  );

  // A short queue decouples the front from the scanner, so whitespace release and
  // output backpressure do not stall each other cycle by cycle.
  ccs_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (front_valid),
    .push_ready_o (front_ready),
    .push_tok_i   (front_tok),
    .pop_valid_o  (back_valid),
    .pop_ready_i  (back_ready),
    .pop_tok_o    (back_tok)
  );

  // The back recognizes comments and marks the last result of every input beat.
  ccs_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .tok_valid_i   (back_valid),
    .tok_ready_o   (back_ready),
    .tok_i         (back_tok),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .byte_valid_o  (byte_valid_o),
    .out_byte_o    (out_byte_o),
    .last_of_run_o (last_of_run_o),
    .trim_lost_o   (trim_lost_o),
    .text_done_o   (text_done_o)
  );

`ifndef ASSERT_OFF
  // The end of text always closes the beat it belongs to.
  a_done_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && text_done_o |-> last_of_run_o)
    else $error("text_done without last_of_run");

  // An empty result appears only as the closing result of an end-of-text beat.
  a_empty_only_at_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !byte_valid_o |-> text_done_o && (out_byte_o == 8'h00) && !trim_lost_o)
    else $error("empty result outside end of text");

  // An end-of-text beat always issues work, so the input must go busy.
  a_eot_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && kind_i |=> !in_ready_o)
    else $error("end of text did not occupy the front");
`endif

endmodule

`default_nettype wire
